// ===== hw/rtl/bdq_pkg.sv =====
// shared types and codes for the bounded deque
package bdq_pkg;

   // operation codes carried in the kind field
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_LIST_ALL   = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_POP_BACK   = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int unsigned OCC_WIDTH = 6;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
   } bdq_req_type;

   typedef struct packed {
      logic signed [31:0]    element;
      logic [1:0]            status;
      logic [OCC_WIDTH-1:0]  occupancy;
      logic                  last;
   } bdq_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic advance;
   } bdq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic kind_ok;
      logic list_more;
   } bdq_stat_type;

endpackage

// ===== hw/rtl/bdq_ctrl.sv =====
// handshake controller for the bounded deque
module bdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bdq_pkg::bdq_stat_type stat,
   output bdq_pkg::bdq_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;
   logic      accept;
   logic      take;

   assign accept      = req_valid & ready_ff;
   assign take        = valid_ff & rsp_ready;
   assign cmd.start   = accept;
   assign cmd.advance = take & stat.list_more;
   assign req_ready   = ready_ff;
   assign rsp_valid   = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && stat.kind_ok) begin
                  state_ff <= ST_RESP;
                  ready_ff <= 1'b0;
                  valid_ff <= 1'b1;
               end
            end
            ST_RESP: begin
               if (take && !stat.list_more) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
                  valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   // never take a new word while a result is on offer
   a_excl: assert property (@(posedge clock) disable iff (reset) !(ready_ff && valid_ff))
      else $error("ready and valid high together");

   // a valid operation always produces a result in the next cycle
   a_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && stat.kind_ok) |=> valid_ff)
      else $error("accepted word without result");

endmodule

// ===== hw/rtl/bdq_dpath.sv =====
// ring store, pointers and result register for the bounded deque
module bdq_dpath #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bdq_pkg::bdq_req_type  req_data,
   input  bdq_pkg::bdq_cmd_type  cmd,
   output bdq_pkg::bdq_stat_type stat,
   output bdq_pkg::bdq_rsp_type  rsp_data
);

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [VALUE_WIDTH-1:0] store_mem [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   logic [PW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] list_ptr_ff, list_ptr_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          listing_ff, listing_in;
   logic [1:0]    status_ff, status_in;
   logic          elem_sel_ff, elem_sel_in;

   logic          wr_en, rd_en;
   logic [PW-1:0] wr_addr, rd_addr;
   logic [PW-1:0] front_m1, front_p1, list_next, back_idx, last_idx;
   logic [CW:0]   back_sum, last_sum;
   logic          full, empty, kind_ok;
   logic signed [VALUE_WIDTH-1:0] wr_value;

   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign front_m1 = (front_ff == '0) ? PW'(CAPACITY - 1) : front_ff - PW'(1);
   assign front_p1 = (front_ff == PW'(CAPACITY - 1)) ? '0 : front_ff + PW'(1);
   assign list_next = (list_ptr_ff == PW'(CAPACITY - 1)) ? '0 : list_ptr_ff + PW'(1);
   assign back_sum = (CW+1)'(front_ff) + (CW+1)'(count_ff);
   assign last_sum = back_sum - (CW+1)'(1);
   assign back_idx = (back_sum >= (CW+1)'(CAPACITY)) ?
                     PW'(back_sum - (CW+1)'(CAPACITY)) : PW'(back_sum);
   assign last_idx = (last_sum >= (CW+1)'(CAPACITY)) ?
                     PW'(last_sum - (CW+1)'(CAPACITY)) : PW'(last_sum);
   assign wr_value = VALUE_WIDTH'(req_data.value);
   assign kind_ok  = (req_data.kind <= bdq_pkg::KIND_POP_BACK);

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      list_ptr_in = list_ptr_ff;
      remain_in   = remain_ff;
      listing_in  = listing_ff;
      status_in   = status_ff;
      elem_sel_in = elem_sel_ff;
      wr_en       = 1'b0;
      wr_addr     = back_idx;
      rd_en       = 1'b0;
      rd_addr     = front_ff;
      if (cmd.start && kind_ok) begin
         listing_in  = 1'b0;
         remain_in   = '0;
         elem_sel_in = 1'b0;
         status_in   = bdq_pkg::STATUS_OK;
         unique case (req_data.kind)
            bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (req_data.kind == bdq_pkg::KIND_PUSH_FRONT) begin
                     wr_addr  = front_m1;
                     front_in = front_m1;
                  end
               end
            end
            bdq_pkg::KIND_LIST_ALL: begin
               if (empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  rd_en       = 1'b1;
                  list_ptr_in = front_ff;
                  remain_in   = count_ff - CW'(1);
                  listing_in  = 1'b1;
                  elem_sel_in = 1'b1;
               end
            end
            default: begin
               // pop front or pop back
               if (empty) begin
                  status_in = bdq_pkg::STATUS_EMPTY;
               end else begin
                  rd_en       = 1'b1;
                  elem_sel_in = 1'b1;
                  count_in    = count_ff - CW'(1);
                  if (req_data.kind == bdq_pkg::KIND_POP_FRONT) begin
                     front_in = front_p1;
                  end else begin
                     rd_addr = last_idx;
                  end
               end
            end
         endcase
      end else if (cmd.advance) begin
         rd_en       = 1'b1;
         rd_addr     = list_next;
         list_ptr_in = list_next;
         remain_in   = remain_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         listing_ff <= 1'b0;
         remain_ff  <= '0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         listing_ff <= listing_in;
         remain_ff  <= remain_in;
      end
      list_ptr_ff <= list_ptr_in;
      status_ff   <= status_in;
      elem_sel_ff <= elem_sel_in;
   end

   assign stat.kind_ok   = kind_ok;
   assign stat.list_more = listing_ff && (remain_ff != '0);

   assign rsp_data.element   = elem_sel_ff ? 32'(rd_data_ff) : '0;
   assign rsp_data.status    = status_ff;
   assign rsp_data.occupancy = bdq_pkg::OCC_WIDTH'(count_ff);
   assign rsp_data.last      = !listing_ff || (remain_ff == '0);

   // occupancy never passes capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count above capacity");

   // a listing walk never runs past the stored elements
   a_walk: assert property (@(posedge clock) disable iff (reset)
      listing_ff |-> (remain_ff < count_ff))
      else $error("listing past occupancy");

endmodule

// ===== hw/rtl/bounded_deque_with_listing.sv =====
// bounded deque top level: push or pop at either end, list from front to back
// result: a push or pop result is registered and offered in the cycle after the word is accepted
// push and pop: no new word is accepted until the result of the last one has been taken
// listing: first element in the cycle after accept, then one element per cycle while results are taken at once
// rate is set by the single result register and the one read port of the ring store
// reset: pointer and count cleared, store contents undefined until written, no clearing pass
module bounded_deque_with_listing #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // request side
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdq_pkg::bdq_req_type req_data,
   // response side
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdq_pkg::bdq_rsp_type rsp_data
);

   // command and status between the controller and the datapath
   bdq_pkg::bdq_cmd_type  cmd;
   bdq_pkg::bdq_stat_type stat;

   // controller: idle waiting for a word, or offering a result
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: ring store with registered read, front pointer, count, listing walk
   bdq_dpath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/bounded_deque_with_listing_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the bounded deque with listing
module bounded_deque_with_listing_test;

   localparam int DEPTH          = 32;
   localparam int WIDTH          = 32;
   localparam int IDLE_PCT       = 29;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_WORDS    = 65;
   // window of offered words during which neither side idles
   localparam int STEADY_FROM    = 150;
   localparam int STEADY_TO      = 250;

   // kinds the block has to ignore
   localparam logic [2:0] KIND_SPARE_5 = 3'd5;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   // push share of each random phase: fill up, drain, and a balanced mix
   localparam int PUSH_GROW   = 75;
   localparam int PUSH_SHRINK = 14;
   localparam int PUSH_MIXED  = 45;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   bdq_pkg::bdq_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   bdq_pkg::bdq_rsp_type rsp_data;
   logic                 steady    = 1'b0;

   // words waiting for the driver, and results the deque still owes
   bdq_pkg::bdq_req_type word_backlog[$];
   bdq_pkg::bdq_rsp_type owed_results[$];

   int queued_words   = 0;
   int offered_words  = 0;
   int accepted_words = 0;
   int quiet_cycles   = 0;
   int error_count    = 0;

   // shadow copy of the deque contents
   logic signed [31:0] shadow_store [DEPTH];
   int                 shadow_front = 0;
   int                 shadow_count = 0;

   bounded_deque_with_listing #(
      .CAPACITY    (DEPTH),
      .VALUE_WIDTH (WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // advance the shadow deque by one accepted word and queue what it must produce
   task automatic deque_apply(input bdq_pkg::bdq_req_type w);
      bdq_pkg::bdq_rsp_type r;
      int                   slot;
      int                   i;
      r        = '0;
      r.status = bdq_pkg::STATUS_OK;
      r.last   = 1'b1;
      case (w.kind)
         bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               // full: word dropped, count unchanged
               r.status = bdq_pkg::STATUS_FULL;
            end else begin
               if (w.kind == bdq_pkg::KIND_PUSH_FRONT) begin
                  shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                  slot = shadow_front;
               end else begin
                  slot = (shadow_front + shadow_count) % DEPTH;
               end
               shadow_store[slot] = w.value;
               shadow_count++;
            end
            r.occupancy = shadow_count[bdq_pkg::OCC_WIDTH-1:0];
            owed_results.push_back(r);
         end
         bdq_pkg::KIND_LIST_ALL: begin
            if (shadow_count == 0) begin
               r.status = bdq_pkg::STATUS_EMPTY;
               owed_results.push_back(r);
            end else begin
               // one result per element, front to back, last only on the back one
               for (i = 0; i < shadow_count; i++) begin
                  r.element   = shadow_store[(shadow_front + i) % DEPTH];
                  r.occupancy = shadow_count[bdq_pkg::OCC_WIDTH-1:0];
                  r.last      = (i == shadow_count - 1);
                  owed_results.push_back(r);
               end
            end
         end
         bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK: begin
            if (shadow_count == 0) begin
               r.status = bdq_pkg::STATUS_EMPTY;
            end else begin
               if (w.kind == bdq_pkg::KIND_POP_FRONT) begin
                  slot = shadow_front;
                  shadow_front = (shadow_front + 1) % DEPTH;
               end else begin
                  slot = (shadow_front + shadow_count - 1) % DEPTH;
               end
               shadow_count--;
               r.element = shadow_store[slot];
            end
            r.occupancy = shadow_count[bdq_pkg::OCC_WIDTH-1:0];
            owed_results.push_back(r);
         end
         default: begin
            // spare kinds: no result, no state change
         end
      endcase
   endtask

   // driver: request word and response back-pressure, both idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
         steady    <= 1'b0;
      end else begin
         steady    <= (offered_words >= STEADY_FROM && offered_words < STEADY_TO);
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         // a word on the bus is held until taken
         if (!req_valid || req_ready) begin
            if (word_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_data  <= word_backlog.pop_front();
               req_valid <= 1'b1;
               offered_words++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on every accepted request, check every accepted response
   always @(posedge clock) begin : monitor_blk
      bdq_pkg::bdq_rsp_type want;
      if (!reset) begin
         // prediction first, so a same-edge result would still find its expectation
         if (req_valid && req_ready) begin
            deque_apply(req_data);
            accepted_words++;
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch($sformatf("result word %h with nothing owed", rsp_data));
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.element !== want.element)
                  report_mismatch($sformatf("element got %0d want %0d",
                                            rsp_data.element, want.element));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy got %0d want %0d",
                                            rsp_data.occupancy, want.occupancy));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b",
                                            rsp_data.last, want.last));
            end
         end
         // watchdog on cycles where neither channel moves a word
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   task automatic queue_word(input logic [2:0] kind, input logic [31:0] value);
      bdq_pkg::bdq_req_type w;
      w.kind  = kind;
      w.value = value;
      word_backlog.push_back(w);
      queued_words++;
   endtask

   // hold off the sender until every word is taken and every result is back
   task automatic wait_settled();
      while (word_backlog.size() != 0 || accepted_words != queued_words ||
             owed_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [2:0] pick_kind(input int push_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) begin
         case ($urandom_range(2))
            0:       return KIND_SPARE_5;
            1:       return KIND_SPARE_6;
            default: return KIND_SPARE_7;
         endcase
      end
      // listings kept rare, each can cost a full deque of results
      if (roll < 11)
         return bdq_pkg::KIND_LIST_ALL;
      if (roll < 11 + push_pct)
         return $urandom_range(1) ? bdq_pkg::KIND_PUSH_BACK : bdq_pkg::KIND_PUSH_FRONT;
      return $urandom_range(1) ? bdq_pkg::KIND_POP_BACK : bdq_pkg::KIND_POP_FRONT;
   endfunction

   // mostly full-range values, now and then one of the extremes
   function automatic logic [31:0] pick_value();
      if ($urandom_range(7) != 0)
         return $urandom;
      case ($urandom_range(3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   initial begin : stimulus
      int push_share [6];
      int p;
      int n;
      push_share = '{PUSH_GROW, PUSH_SHRINK, PUSH_GROW, PUSH_MIXED, PUSH_SHRINK, PUSH_MIXED};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cases first
      queue_word(bdq_pkg::KIND_LIST_ALL, 32'h0);
      queue_word(bdq_pkg::KIND_POP_FRONT, 32'h1234_5678);
      queue_word(bdq_pkg::KIND_POP_BACK, 32'hFFFF_FFFF);
      // extremes at both ends, then list them front to back
      queue_word(bdq_pkg::KIND_PUSH_BACK, 32'h7FFF_FFFF);
      queue_word(bdq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
      queue_word(bdq_pkg::KIND_PUSH_BACK, 32'h0000_0000);
      queue_word(bdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
      queue_word(bdq_pkg::KIND_LIST_ALL, 32'h0);
      // spare kinds leave the deque alone
      queue_word(KIND_SPARE_5, 32'h5555_AAAA);
      queue_word(KIND_SPARE_6, 32'hAAAA_5555);
      queue_word(KIND_SPARE_7, 32'hFFFF_FFFF);
      // drain from both ends, one pop past empty
      queue_word(bdq_pkg::KIND_POP_FRONT, 32'h0);
      queue_word(bdq_pkg::KIND_POP_BACK, 32'h0);
      queue_word(bdq_pkg::KIND_POP_FRONT, 32'h0);
      queue_word(bdq_pkg::KIND_POP_BACK, 32'h0);
      queue_word(bdq_pkg::KIND_POP_BACK, 32'h0);
      // single element listing
      queue_word(bdq_pkg::KIND_PUSH_FRONT, 32'h5555_AAAA);
      queue_word(bdq_pkg::KIND_LIST_ALL, 32'h0);
      queue_word(bdq_pkg::KIND_POP_BACK, 32'h0);
      queue_word(bdq_pkg::KIND_PUSH_BACK, 32'hAAAA_5555);
      wait_settled();

      // random phases, fill toward full and drain toward empty,
      // with the sender paused between phases until all results are in
      for (p = 0; p < 6; p++) begin
         for (n = 0; n < PHASE_WORDS; n++)
            queue_word(pick_kind(push_share[p]), pick_value());
         wait_settled();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
